@@ hw/rtl/atrp_pkg.sv @@
// Shared types and constants for the traits record parser.
// No dependencies; imported by every module of the block.
package atrp_pkg;

  // header_kind register codes
  localparam logic [1:0] HDR_INSTANCE  = 2'd0;
  localparam logic [1:0] HDR_INIT_ONLY = 2'd1;

  // trait tag fields
  localparam int unsigned TAG_MD_BIT      = 6;
  localparam int unsigned FLAGS_PROTNS_BIT = 3;
  localparam logic [3:0]  KIND_SLOT       = 4'd0;
  localparam logic [3:0]  KIND_CONST      = 4'd6;
  localparam logic [3:0]  KIND_MAX_FIELDS = 4'd6;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_QNAME  = 5'd1,
    PH_BASE   = 5'd2,
    PH_FLAGS  = 5'd3,
    PH_PROTNS = 5'd4,
    PH_ICOUNT = 5'd5,
    PH_IFACE  = 5'd6,
    PH_INIT   = 5'd7,
    PH_COUNT  = 5'd8,
    PH_NAME   = 5'd9,
    PH_TAG    = 5'd10,
    PH_ID     = 5'd11,
    PH_TYPE   = 5'd12,
    PH_INDEX  = 5'd13,
    PH_VKIND  = 5'd14,
    PH_MCOUNT = 5'd15,
    PH_MITEM  = 5'd16
  } atrp_phase_t;

  // one classified input byte
  typedef struct packed {
    logic       start;  // first byte of a record
    logic       cont;   // u30 continuation bit
    logic [7:0] data;
  } atrp_byte_t;

endpackage

@@ hw/rtl/abc_traits_record_parser_unit.sv @@
// Top level of the traits record parser: config register, front stage,
// byte queue and parser. Depends on atrp_pkg, atrp_front, atrp_queue, atrp_back.
//
// Accepts one record byte per cycle while in_ready is high and gives at most
// one result per byte; a trait result passes the front register, a queue
// entry and then the output register after its final byte is accepted.
// Sustained rate is one byte per clock while results are taken, set by the
// combinational u30 accumulate and phase update in the parser. While a
// result waits to be taken, the queue and the front register hold up to
// QUEUE_DEPTH + 1 bytes before the input stalls. header_kind is sampled when
// the record start byte is parsed; write it only while the block is idle.
module abc_traits_record_parser_unit
  import atrp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        record_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] trait_index,
  output logic [31:0] name_index,
  output logic        is_mapping,
  output logic        last
);

  logic       header_kind_q;
  logic [1:0] header_kind;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  atrp_byte_t push_item, pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_kind <= HDR_INSTANCE;
    end else if (cfg_valid && cfg_ready) begin
      header_kind <= cfg_data;
    end
  end

  atrp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .record_start (record_start),
    .push_valid   (push_valid),
    .push_item    (push_item),
    .push_ready   (push_ready)
  );

  atrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  atrp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .header_kind  (header_kind),
    .pop_valid    (pop_valid),
    .pop_item     (pop_item),
    .pop_ready    (pop_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .trait_index  (trait_index),
    .name_index   (name_index),
    .is_mapping   (is_mapping),
    .last         (last)
  );

  // flags a config write that changed header_kind, kept for debug visibility of writes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_kind_q <= 1'b0;
    end else begin
      header_kind_q <= cfg_valid && cfg_ready && (cfg_data != header_kind);
    end
  end

  a_cfg_applied: assert property (@(posedge clk) disable iff (rst)
    header_kind_q |-> header_kind == $past(cfg_data))
    else $error("config write not applied");

endmodule

@@ hw/rtl/atrp_front.sv @@
// Front stage: registers each accepted byte and classifies it.
// Depends on atrp_pkg.
module atrp_front
  import atrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       record_start,
  output logic       push_valid,
  output atrp_byte_t push_item,
  input  logic       push_ready
);

  logic       held;
  atrp_byte_t item;

  assign in_ready   = !held || push_ready;
  assign push_valid = held;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.start <= record_start;
      item.cont  <= data_byte[7];
      item.data  <= data_byte;
    end
  end

endmodule

@@ hw/rtl/atrp_queue.sv @@
// Short FIFO between the front stage and the parser.
// Depends on atrp_pkg; DEPTH must be a power of two, at least 2.
module atrp_queue
  import atrp_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  input  atrp_byte_t push_item,
  output logic       push_ready,
  output logic       pop_valid,
  output atrp_byte_t pop_item,
  input  logic       pop_ready
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  atrp_byte_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

@@ hw/rtl/atrp_back.sv @@
// Parser: walks the header and traits one byte per cycle unless a result stalls,
// decodes u30 fields and drives the registered result outputs. Depends on atrp_pkg.
module atrp_back
  import atrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  header_kind,
  input  logic        pop_valid,
  input  atrp_byte_t  pop_item,
  output logic        pop_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] trait_index,
  output logic [31:0] name_index,
  output logic        is_mapping,
  output logic        last
);

  atrp_phase_t phase, phase_next, start_phase, cur_phase;

  logic [31:0] acc, acc_eff, acc_next, shifted, vint;
  logic [2:0]  cnt, cnt_eff, cnt_next;
  logic        vdone, varint_phase;
  logic [31:0] traits_left, items_left, cur_name, cur_method;
  logic [31:0] traits_dec, items_dec;
  logic [3:0]  cur_kind, tag_kind;
  logic        has_md, tag_md, two_idx, last_trait, items_done, pop;
  logic        emit, emit_map, emit_last;
  logic [31:0] emit_method, emit_name;

  assign pop       = pop_valid && (!out_valid || out_ready);
  assign pop_ready = !out_valid || out_ready;

  always_comb begin
    unique case (header_kind)
      HDR_INSTANCE:  start_phase = PH_QNAME;
      HDR_INIT_ONLY: start_phase = PH_INIT;
      default:       start_phase = PH_COUNT;
    endcase
  end

  // a record start restarts the walk with a clean u30 accumulator
  assign cur_phase = pop_item.start ? start_phase : phase;
  assign acc_eff   = pop_item.start ? '0 : acc;
  assign cnt_eff   = pop_item.start ? '0 : cnt;

  always_comb begin
    case (cnt_eff[1:0])
      2'd0:    shifted = {25'b0, pop_item.data[6:0]};
      2'd1:    shifted = {18'b0, pop_item.data[6:0], 7'b0};
      2'd2:    shifted = {11'b0, pop_item.data[6:0], 14'b0};
      default: shifted = {4'b0, pop_item.data[6:0], 21'b0};
    endcase
  end

  // fifth byte: only its low nibble is taken, shifted by 28
  assign vint  = cnt_eff[2] ? (acc_eff | {pop_item.data[3:0], 28'b0}) : (acc_eff | shifted);
  assign vdone = cnt_eff[2] || !pop_item.cont;

  assign varint_phase = !(cur_phase == PH_IDLE || cur_phase == PH_FLAGS ||
                          cur_phase == PH_TAG  || cur_phase == PH_VKIND);
  assign acc_next = varint_phase ? (vdone ? '0 : vint) : acc_eff;
  assign cnt_next = varint_phase ? (vdone ? '0 : cnt_eff + 3'd1) : cnt_eff;

  assign tag_kind   = pop_item.data[3:0];
  assign tag_md     = pop_item.data[TAG_MD_BIT];
  assign two_idx    = (cur_kind == KIND_SLOT) || (cur_kind == KIND_CONST);
  assign traits_dec = traits_left - 32'd1;
  assign items_dec  = items_left - 32'd1;
  assign last_trait = (traits_dec == '0);
  assign items_done = (items_dec == '0);

  // next phase
  always_comb begin
    phase_next = phase;
    if (pop) begin
      phase_next = cur_phase;
      unique case (cur_phase)
        PH_IDLE:   phase_next = PH_IDLE;
        PH_FLAGS:  phase_next = pop_item.data[FLAGS_PROTNS_BIT] ? PH_PROTNS : PH_ICOUNT;
        PH_TAG: begin
          if (tag_kind <= KIND_MAX_FIELDS) begin
            phase_next = PH_ID;
          end else if (tag_md) begin
            phase_next = PH_MCOUNT;
          end else begin
            phase_next = last_trait ? PH_IDLE : PH_NAME;
          end
        end
        PH_VKIND: begin
          if (has_md) begin
            phase_next = PH_MCOUNT;
          end else begin
            phase_next = last_trait ? PH_IDLE : PH_NAME;
          end
        end
        PH_QNAME:  if (vdone) phase_next = PH_BASE;
        PH_BASE:   if (vdone) phase_next = PH_FLAGS;
        PH_PROTNS: if (vdone) phase_next = PH_ICOUNT;
        PH_ICOUNT: if (vdone) phase_next = (vint == '0) ? PH_INIT : PH_IFACE;
        PH_IFACE:  if (vdone && items_done) phase_next = PH_INIT;
        PH_INIT:   if (vdone) phase_next = PH_COUNT;
        PH_COUNT:  if (vdone) phase_next = (vint == '0) ? PH_IDLE : PH_NAME;
        PH_NAME:   if (vdone) phase_next = PH_TAG;
        PH_ID:     if (vdone) phase_next = two_idx ? PH_TYPE : PH_INDEX;
        PH_TYPE:   if (vdone) phase_next = PH_INDEX;
        PH_INDEX: begin
          if (vdone) begin
            if (two_idx && vint != '0) begin
              phase_next = PH_VKIND;
            end else if (has_md) begin
              phase_next = PH_MCOUNT;
            end else begin
              phase_next = last_trait ? PH_IDLE : PH_NAME;
            end
          end
        end
        PH_MCOUNT: begin
          if (vdone) begin
            if (vint == '0) begin
              phase_next = last_trait ? PH_IDLE : PH_NAME;
            end else begin
              phase_next = PH_MITEM;
            end
          end
        end
        PH_MITEM:  if (vdone && items_done) phase_next = last_trait ? PH_IDLE : PH_NAME;
        default:   phase_next = PH_IDLE;
      endcase
    end
  end

  // result of the current byte
  always_comb begin
    emit        = 1'b0;
    emit_map    = 1'b1;
    emit_last   = last_trait;
    emit_method = cur_method;
    emit_name   = cur_name;
    unique case (cur_phase)
      PH_TAG:    emit = (tag_kind > KIND_MAX_FIELDS) && !tag_md;
      PH_VKIND:  emit = !has_md;
      PH_COUNT: begin
        if (vdone && vint == '0) begin
          emit        = 1'b1;
          emit_map    = 1'b0;
          emit_last   = 1'b1;
          emit_method = '0;
          emit_name   = '0;
        end
      end
      PH_INDEX: begin
        emit        = vdone && !(two_idx && vint != '0) && !has_md;
        emit_method = vint;
      end
      PH_MCOUNT: emit = vdone && (vint == '0);
      PH_MITEM:  emit = vdone && items_done;
      default:   emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      cnt         <= '0;
      traits_left <= '0;
      items_left  <= '0;
      cur_name    <= '0;
      cur_method  <= '0;
      cur_kind    <= '0;
      has_md      <= 1'b0;
    end else if (pop) begin
      acc <= acc_next;
      cnt <= cnt_next;
      if (pop_item.start) begin
        traits_left <= '0;
        items_left  <= '0;
        cur_name    <= '0;
        cur_method  <= '0;
        cur_kind    <= '0;
        has_md      <= 1'b0;
      end
      case (cur_phase) inside
        PH_FLAGS: has_md <= pop_item.data[FLAGS_PROTNS_BIT];
        PH_TAG: begin
          cur_kind <= tag_kind;
          has_md   <= tag_md;
        end
        PH_ICOUNT, PH_MCOUNT: if (vdone) items_left <= vint;
        PH_IFACE, PH_MITEM:   if (vdone) items_left <= items_dec;
        PH_COUNT:             if (vdone) traits_left <= vint;
        PH_NAME: begin
          if (vdone) begin
            cur_name   <= vint;
            cur_method <= '0;
          end
        end
        PH_INDEX:             if (vdone) cur_method <= vint;
        default: ;
      endcase
      if (emit && emit_map) begin
        traits_left <= traits_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      trait_index <= emit_method;
      name_index  <= emit_name;
      is_mapping  <= emit_map;
      last        <= emit_last;
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_mapping |-> last && trait_index == '0 && name_index == '0)
    else $error("empty-record result without last or with nonzero indices");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    pop && emit && emit_last |=> phase == PH_IDLE)
    else $error("parser not idle after record end");

  a_varint_len: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'd4)
    else $error("u30 byte count beyond five bytes");

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !pop)
    else $error("byte consumed while result stalled");

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for abc_traits_record_parser_unit: directed and random
// traits records are fed byte by byte and the trait results are compared with
// an in-bench parser model. Depends on atrp_pkg and the parser RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import atrp_pkg::*;

  // header kinds beyond the package codes: both mean no header
  localparam logic [1:0] HDR_NONE     = 2'd2;
  localparam logic [1:0] HDR_NONE_ALT = 2'd3;

  typedef struct packed {
    logic [31:0] method_idx;
    logic [31:0] name_idx;
    logic        mapping;
    logic        ends;
  } trait_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = 2'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        record_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] trait_index;
  logic [31:0] name_index;
  logic        is_mapping;
  logic        last;

  abc_traits_record_parser_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .record_start (record_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .trait_index  (trait_index),
    .name_index   (name_index),
    .is_mapping   (is_mapping),
    .last         (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parser model state
  logic [1:0]    hdr_kind = HDR_INSTANCE;
  atrp_phase_t   ph = PH_IDLE;
  logic [31:0]   acc = '0;
  logic [2:0]    acc_bytes = '0;
  logic [31:0]   traits_left = '0;
  logic [31:0]   list_left = '0;
  logic [31:0]   cur_name = '0;
  logic [31:0]   cur_method = '0;
  logic [3:0]    cur_kind = '0;
  logic          md_pending = 1'b0;

  trait_result_t expected_traits[$];
  logic [7:0]    record_bytes[$];
  int            parsed_items = 0;
  int            fail_count = 0;
  bit            idle_on = 1'b1;

  always @(negedge clk) begin
    out_ready <= !idle_on || ($urandom_range(99) >= 7);
  end

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic close_trait();
    logic done_flag;
    traits_left = traits_left - 1;
    done_flag = (traits_left == 0);
    expected_traits.push_back('{cur_method, cur_name, 1'b1, done_flag});
    ph = done_flag ? PH_IDLE : PH_NAME;
  endtask

  task automatic fields_done();
    if (md_pending) ph = PH_MCOUNT;
    else close_trait();
  endtask

  task automatic model_byte(input logic [7:0] b, input logic s);
    logic [31:0] v;
    logic        slot_like;
    if (s) begin
      acc = '0;
      acc_bytes = '0;
      traits_left = '0;
      list_left = '0;
      cur_name = '0;
      cur_method = '0;
      cur_kind = '0;
      md_pending = 1'b0;
      case (hdr_kind)
        HDR_INSTANCE:  ph = PH_QNAME;
        HDR_INIT_ONLY: ph = PH_INIT;
        default:       ph = PH_COUNT;
      endcase
    end
    if (ph != PH_IDLE) parsed_items++;
    case (ph)
      PH_IDLE: return;
      PH_FLAGS: begin
        md_pending = b[FLAGS_PROTNS_BIT];
        ph = md_pending ? PH_PROTNS : PH_ICOUNT;
        return;
      end
      PH_TAG: begin
        cur_kind = b[3:0];
        md_pending = b[TAG_MD_BIT];
        if (cur_kind <= KIND_MAX_FIELDS) ph = PH_ID;
        else fields_done();
        return;
      end
      PH_VKIND: begin
        fields_done();
        return;
      end
      default: ;
    endcase

    // u30: the fifth byte always ends the value, only its low nibble lands
    if (acc_bytes < 4) begin
      acc |= 32'(b[6:0]) << (7 * acc_bytes);
      if (b[7]) begin
        acc_bytes++;
        return;
      end
    end else begin
      acc |= {b[3:0], 28'd0};
    end
    v = acc;
    acc = '0;
    acc_bytes = '0;

    slot_like = (cur_kind == KIND_SLOT) || (cur_kind == KIND_CONST);
    case (ph)
      PH_QNAME:  ph = PH_BASE;
      PH_BASE:   ph = PH_FLAGS;
      PH_PROTNS: ph = PH_ICOUNT;
      PH_ICOUNT: begin
        list_left = v;
        ph = (v == 0) ? PH_INIT : PH_IFACE;
      end
      PH_IFACE: begin
        list_left = list_left - 1;
        if (list_left == 0) ph = PH_INIT;
      end
      PH_INIT:   ph = PH_COUNT;
      PH_COUNT: begin
        traits_left = v;
        if (v == 0) begin
          ph = PH_IDLE;
          expected_traits.push_back('{32'd0, 32'd0, 1'b0, 1'b1});
        end else begin
          ph = PH_NAME;
        end
      end
      PH_NAME: begin
        cur_name = v;
        cur_method = '0;
        ph = PH_TAG;
      end
      PH_ID:     ph = slot_like ? PH_TYPE : PH_INDEX;
      PH_TYPE:   ph = PH_INDEX;
      PH_INDEX: begin
        cur_method = v;
        if (slot_like && v != 0) ph = PH_VKIND;
        else fields_done();
      end
      PH_MCOUNT: begin
        list_left = v;
        if (v == 0) close_trait();
        else ph = PH_MITEM;
      end
      PH_MITEM: begin
        list_left = list_left - 1;
        if (list_left == 0) close_trait();
      end
      default: ph = PH_IDLE;
    endcase
  endtask

  always @(posedge clk) begin
    trait_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_traits.size() == 0) begin
        note_failure($sformatf("unexpected result trait_index %h name_index %h",
                               trait_index, name_index));
      end else begin
        want = expected_traits.pop_front();
        if (trait_index !== want.method_idx)
          note_failure($sformatf("trait_index expected %h got %h",
                                 want.method_idx, trait_index));
        if (name_index !== want.name_idx)
          note_failure($sformatf("name_index expected %h got %h",
                                 want.name_idx, name_index));
        if (is_mapping !== want.mapping)
          note_failure($sformatf("is_mapping expected %b got %b", want.mapping, is_mapping));
        if (last !== want.ends)
          note_failure($sformatf("last expected %b got %b", want.ends, last));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    @(negedge clk);
    if (idle_on && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    record_start <= s;
    do @(posedge clk); while (!in_ready);
    model_byte(b, s);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_traits.size() != 0) @(negedge clk);
  endtask

  task automatic write_header_kind(input logic [1:0] kind);
    drain_results();
    // bytes that give no result may still sit in the pipeline
    repeat (16) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= kind;
    do @(posedge clk); while (!cfg_ready);
    hdr_kind = kind;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // u30 of a known value, padded with continuation bytes up to min_len
  task automatic add_u30(input logic [31:0] v, input int min_len);
    int         len;
    logic [7:0] bv;
    len = 1;
    while (len < 5 && (v >> (7 * len)) != 0) len++;
    if (min_len > len) len = min_len;
    for (int i = 0; i < len; i++) begin
      if (i == 4) begin
        bv = {4'($urandom_range(15)), v[31:28]};
      end else begin
        bv = {1'b0, 7'(v >> (7 * i))};
        bv[7] = (i < len - 1);
      end
      record_bytes.push_back(bv);
    end
  endtask

  task automatic add_u30_rand(input bit nonzero);
    int         len;
    logic [7:0] bv;
    if (!nonzero && $urandom_range(3) == 0) begin
      add_u30(32'd0, $urandom_range(1, 3));
      return;
    end
    len = $urandom_range(1, 5);
    for (int i = 0; i < len; i++) begin
      if (i == 4) begin
        bv = 8'($urandom_range(255));
      end else begin
        bv = {1'b0, 7'($urandom_range(127))};
        bv[7] = (i < len - 1);
        if (i == 0 && nonzero && bv[6:0] == 7'd0) bv[0] = 1'b1;
      end
      record_bytes.push_back(bv);
    end
  endtask

  task automatic build_record(input logic [1:0] kind, input int ntraits);
    logic [7:0] flags;
    logic [7:0] tag;
    int         n_iface;
    int         tk;
    int         n_md;
    record_bytes.delete();
    if (kind == HDR_INSTANCE) begin
      add_u30_rand(1'b0);
      add_u30_rand(1'b0);
      flags = 8'($urandom_range(255));
      record_bytes.push_back(flags);
      if (flags[FLAGS_PROTNS_BIT]) add_u30_rand(1'b0);
      n_iface = $urandom_range(3);
      add_u30(n_iface, $urandom_range(1, 2));
      repeat (n_iface) add_u30_rand(1'b0);
    end
    if (kind == HDR_INSTANCE || kind == HDR_INIT_ONLY) add_u30_rand(1'b0);
    add_u30(ntraits, $urandom_range(1, 2));
    repeat (ntraits) begin
      add_u30_rand(1'b0);
      tk = ($urandom_range(9) < 7) ? $urandom_range(6) : $urandom_range(15, 7);
      tag = 8'($urandom_range(255));
      tag[3:0] = 4'(tk);
      tag[TAG_MD_BIT] = ($urandom_range(3) == 0);
      record_bytes.push_back(tag);
      if (tk <= KIND_MAX_FIELDS) begin
        add_u30_rand(1'b0);
        if (tk == KIND_SLOT || tk == KIND_CONST) begin
          add_u30_rand(1'b0);
          if ($urandom_range(2) == 0) begin
            add_u30(32'd0, $urandom_range(1, 2));
          end else begin
            add_u30_rand(1'b1);
            record_bytes.push_back(8'($urandom_range(255)));  // value kind
          end
        end else begin
          add_u30_rand(1'b0);
        end
      end
      if (tag[TAG_MD_BIT]) begin
        n_md = $urandom_range(2);
        add_u30(n_md, $urandom_range(1, 2));
        repeat (n_md) add_u30_rand(1'b0);
      end
    end
  endtask

  task automatic send_record(input int n);
    for (int i = 0; i < n; i++) send_byte(record_bytes[i], i == 0);
  endtask

  task automatic test_ignored_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
  endtask

  task automatic test_empty_record();
    write_header_kind(HDR_NONE);
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b1);  // zero count, padded
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_overlong_u30();
    send_byte(8'h01, 1'b1);
    repeat (5) send_byte(8'hff, 1'b0);  // fifth byte ends it despite bit 7
    send_byte(8'h47, 1'b0);             // no-field kind with metadata
    send_byte(8'h00, 1'b0);
    send_byte(8'h05, 1'b0);             // after the end: ignored
  endtask

  task automatic test_restart();
    send_byte(8'h02, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h01, 1'b1);             // new record abandons the old one
    send_byte(8'h7f, 1'b0);
    send_byte(8'h06, 1'b0);             // const, zero value index: no kind byte
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_random_records(input logic [1:0] kind, input int target,
                                     input bit idling, input bit pause_once);
    int goal;
    int r;
    int ntraits;
    int records;
    write_header_kind(kind);
    idle_on = idling;
    goal = parsed_items + target;
    records = 0;
    while (parsed_items < goal) begin
      r = $urandom_range(99);
      if ($urandom_range(9) == 0) ntraits = 0;
      else if ($urandom_range(19) == 0) ntraits = $urandom_range(12, 5);
      else ntraits = $urandom_range(1, 4);
      if (r < 80) begin
        build_record(kind, ntraits);
        send_record(record_bytes.size());
      end else if (r < 90) begin
        build_record(kind, ntraits);
        send_record($urandom_range(1, record_bytes.size()));
      end else begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
      end
      records++;
      if (pause_once && records == 10) drain_results();
    end
  endtask

  initial begin
    int spins;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_ignored_bytes();
    test_empty_record();
    test_overlong_u30();
    test_restart();
    test_random_records(HDR_INSTANCE, 350, 1'b1, 1'b0);
    test_random_records(HDR_INIT_ONLY, 350, 1'b0, 1'b0);
    test_random_records(HDR_NONE, 350, 1'b1, 1'b1);
    test_random_records(HDR_NONE_ALT, 350, 1'b1, 1'b0);
    test_random_records(HDR_INSTANCE, 350, 1'b1, 1'b0);

    @(negedge clk);
    in_valid <= 1'b0;
    spins = 0;
    while (expected_traits.size() != 0 && spins < 20000) begin
      @(negedge clk);
      spins++;
    end
    if (expected_traits.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_traits.size()));
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("PASS abc_traits_record_parser_unit");
    else $display("FAIL abc_traits_record_parser_unit");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL abc_traits_record_parser_unit");
    $finish;
  end

endmodule
